// ===== rtl/dpal_pkg.sv =====
package dpal_pkg;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_PIXEL = 2'd2
    } t_op;

    // Register word indexes with side effects
    localparam logic [4:0] REG_TIMING   = 5'd2;
    localparam logic [4:0] REG_OUTPUT   = 5'd3;
    localparam logic [4:0] REG_HTIM1    = 5'd12;
    localparam logic [4:0] REG_VTIM1    = 5'd16;
    localparam logic [4:0] REG_PAL_ADDR = 5'd28;
    localparam logic [4:0] REG_PAL_DATA = 5'd29;

    // Control bits inside those registers
    localparam int TIMING_HALVE_BIT = 15;
    localparam int OUTPUT_RGB555_BIT = 1;

    // Timing derivation
    localparam logic [11:0] WIDTH_PAD   = 12'd4;
    localparam logic [11:0] WIDTH_MAX   = 12'd800;
    localparam logic [11:0] HEIGHT_MAX  = 12'd600;
    localparam logic [9:0]  WIDTH_RST   = 10'd640;
    localparam logic [9:0]  HEIGHT_RST  = 10'd480;

    localparam logic [31:0] ALPHA_OPAQUE = 32'hFF00_0000;

    // Palette component codes
    localparam logic [1:0] COMP_R = 2'd0;
    localparam logic [1:0] COMP_G = 2'd1;
    localparam logic [1:0] COMP_B = 2'd2;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

endpackage

// ===== rtl/display_regs_palette_pixel_expand_top.sv =====
// Channel | handshake               | payload
// --------+-------------------------+----------------------------------------------------------
// in      | i_in_valid/o_in_ready   | i_op i_reg_index i_write_data i_byte_enable i_pixel_value
// out     | o_out_valid/i_out_ready | o_read_data o_pixel_argb o_frame_width o_frame_height
// config  | i_cfg_we (no wait)      | i_cfg_wdata (indexed mode)
//
// Input register (palette RAM read issued at accept), then result register; an item moves on
// when the result register is empty or being taken, one item per cycle while i_out_ready holds.
// Register file, palette and timing updates commit as an item leaves the input register.
// Sync active-low reset clears control, register file and palette row valid bits;
// an unwritten row reads zero, so no clearing pass is needed.
// An output stall holds a full input register and drops o_in_ready until the result drains.
module display_regs_palette_pixel_expand_top
    import dpal_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256,
    parameter int REGISTER_WORDS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [4:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    input  logic [3:0]  i_byte_enable,
    input  logic [15:0] i_pixel_value,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic [31:0] o_pixel_argb,
    output logic [9:0]  o_frame_width,
    output logic [9:0]  o_frame_height
);

    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
    localparam int RF_AW  = $clog2(REGISTER_WORDS);

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic accept;
    logic advance;

    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stage 1 input register (payload, no reset)
    logic [1:0]  r_op;
    logic [4:0]  r_ri;
    logic [31:0] r_wdata;
    logic [3:0]  r_be;
    logic [15:0] r_pix;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= i_op;
            r_ri    <= i_reg_index;
            r_wdata <= i_write_data;
            r_be    <= i_byte_enable;
            r_pix   <= i_pixel_value;
        end
    end

    // Config register
    logic r_indexed_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_indexed_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_indexed_mode <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Register file and scalar state
    // ------------------------------------------------------------------
    logic [31:0]      r_rf [REGISTER_WORDS];
    logic [7:0]       r_idx;
    logic [1:0]       r_ptr;
    logic [9:0]       r_vis_w;
    logic [9:0]       r_vis_h;

    logic [7:0]       n_idx;
    logic [1:0]       n_ptr;
    logic [9:0]       n_vis_w;
    logic [9:0]       n_vis_h;

    logic [RF_AW-1:0] rf_addr;
    logic             rf_hit;
    logic [31:0]      rf_word;
    logic [31:0]      lane_mask;
    logic [31:0]      merged;
    logic             is_write;

    // primary write port (addressed word) and palette address update port
    logic             rf_we;
    logic [31:0]      rf_wd;
    logic             pa_we;
    logic [31:0]      pa_wd;

    logic [11:0]      w_raw;
    logic [11:0]      w_pad;
    logic [11:0]      h_raw;
    logic [1:0]       ptr_inc;

    // palette write side
    logic             pal_wr;
    logic             idx_in_range;
    logic [PAL_AW-1:0] pal_waddr;
    logic [2:0]       pal_we;
    t_rgb             pal_wd;

    assign rf_addr  = RF_AW'(r_ri);
    assign rf_hit   = 32'(r_ri) < 32'(REGISTER_WORDS);
    assign rf_word  = r_rf[rf_addr];
    assign is_write = (r_op == OP_WRITE) && rf_hit;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            lane_mask[8*k +: 8] = {8{r_be[k]}};
        end
    end

    assign merged = (rf_word & ~lane_mask) | (r_wdata & lane_mask);

    always_comb begin
        unique case (r_ptr)
            2'd0:    ptr_inc = 2'd1;
            2'd1:    ptr_inc = 2'd2;
            2'd2:    ptr_inc = 2'd0;
            default: ptr_inc = 2'd1;
        endcase
    end

    assign w_raw = {1'b0, r_wdata[10:0]} + 12'd1;
    assign w_pad = (r_rf[RF_AW'(REG_TIMING)][TIMING_HALVE_BIT] ? (w_raw >> 1) : w_raw)
                   + WIDTH_PAD;
    assign h_raw = {1'b0, r_wdata[10:0]} + 12'd1;

    assign idx_in_range = {1'b0, r_idx} < 9'(PALETTE_ENTRIES);
    assign pal_waddr    = PAL_AW'(r_idx);

    always_comb begin
        n_idx   = r_idx;
        n_ptr   = r_ptr;
        n_vis_w = r_vis_w;
        n_vis_h = r_vis_h;
        rf_we   = 1'b0;
        rf_wd   = merged;
        pa_we   = 1'b0;
        pa_wd   = 32'd0;
        pal_wr  = 1'b0;
        if (is_write) begin
            rf_we = 1'b1;
            priority if (r_ri == REG_PAL_ADDR) begin
                rf_wd = {24'd0, r_wdata[7:0]};
                n_idx = r_wdata[7:0];
                n_ptr = COMP_R;
            end else if (r_ri == REG_PAL_DATA) begin
                pal_wr = idx_in_range && (r_ptr <= COMP_B);
                n_ptr  = ptr_inc;
                if (ptr_inc == COMP_R) begin
                    n_idx = r_idx + 8'd1;
                end
                pa_we = 1'b1;
                pa_wd = {24'd0, n_idx};
            end else if (r_ri == REG_HTIM1) begin
                n_vis_w = (w_pad > WIDTH_MAX) ? 10'(WIDTH_MAX) : 10'(w_pad);
            end else if (r_ri == REG_VTIM1) begin
                n_vis_h = (h_raw > HEIGHT_MAX) ? 10'(HEIGHT_MAX) : 10'(h_raw);
            end else begin
                // plain register, byte merge only
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REGISTER_WORDS; k++) begin
                r_rf[k] <= 32'd0;
            end
            r_idx   <= 8'd0;
            r_ptr   <= COMP_R;
            r_vis_w <= WIDTH_RST;
            r_vis_h <= HEIGHT_RST;
        end else if (advance) begin
            if (rf_we) begin
                r_rf[rf_addr] <= rf_wd;
            end
            if (pa_we) begin
                r_rf[RF_AW'(REG_PAL_ADDR)] <= pa_wd;
            end
            r_idx   <= n_idx;
            r_ptr   <= n_ptr;
            r_vis_w <= n_vis_w;
            r_vis_h <= n_vis_h;
        end
    end

    // ------------------------------------------------------------------
    // Palette: one RAM per component plus a valid bit per row.
    // The first write to an invalid row zeroes the other two components.
    // ------------------------------------------------------------------
    logic [PALETTE_ENTRIES-1:0] r_row_vld;
    logic                       wr_row_vld;

    assign wr_row_vld = r_row_vld[pal_waddr];

    always_comb begin
        pal_we = 3'b000;
        pal_wd = '0;
        if (pal_wr && advance) begin
            pal_we[0] = (r_ptr == COMP_R) || !wr_row_vld;
            pal_we[1] = (r_ptr == COMP_G) || !wr_row_vld;
            pal_we[2] = (r_ptr == COMP_B) || !wr_row_vld;
        end
        if (r_ptr == COMP_R) begin
            pal_wd.r = r_wdata[7:0];
        end
        if (r_ptr == COMP_G) begin
            pal_wd.g = r_wdata[7:0];
        end
        if (r_ptr == COMP_B) begin
            pal_wd.b = r_wdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (pal_wr && advance) begin
            r_row_vld[pal_waddr] <= 1'b1;
        end
    end

    logic [PAL_AW-1:0] pal_raddr;
    t_rgb              ram_rd;

    assign pal_raddr = PAL_AW'(i_pixel_value[7:0]);

    dpal_ram #(.WIDTH(8), .DEPTH(PALETTE_ENTRIES)) u_ram_r (
        .i_clk   (i_clk),
        .i_we    (pal_we[0]),
        .i_waddr (pal_waddr),
        .i_wdata (pal_wd.r),
        .i_re    (accept),
        .i_raddr (pal_raddr),
        .o_rdata (ram_rd.r)
    );

    dpal_ram #(.WIDTH(8), .DEPTH(PALETTE_ENTRIES)) u_ram_g (
        .i_clk   (i_clk),
        .i_we    (pal_we[1]),
        .i_waddr (pal_waddr),
        .i_wdata (pal_wd.g),
        .i_re    (accept),
        .i_raddr (pal_raddr),
        .o_rdata (ram_rd.g)
    );

    dpal_ram #(.WIDTH(8), .DEPTH(PALETTE_ENTRIES)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (pal_we[2]),
        .i_waddr (pal_waddr),
        .i_wdata (pal_wd.b),
        .i_re    (accept),
        .i_raddr (pal_raddr),
        .o_rdata (ram_rd.b)
    );

    // Forward a palette write that lands on the same edge as the read
    logic [2:0] r_byp_hit;
    t_rgb       r_byp_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 3'b000;
        end else if (accept) begin
            r_byp_hit <= pal_we & {3{pal_waddr == pal_raddr}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byp_data <= pal_wd;
        end
    end

    // ------------------------------------------------------------------
    // Pixel expansion
    // ------------------------------------------------------------------
    logic              pix_in_range;
    logic              pix_row_vld;
    t_rgb              pal_c;
    logic [9:0]        pr;
    logic [9:0]        pg;
    logic [9:0]        pb;
    logic [31:0]       argb;

    assign pix_in_range = {1'b0, r_pix[7:0]} < 9'(PALETTE_ENTRIES);
    assign pix_row_vld  = r_row_vld[PAL_AW'(r_pix[7:0])];

    always_comb begin
        pal_c = '0;
        if (pix_in_range) begin
            pal_c.r = r_byp_hit[0] ? r_byp_data.r : (pix_row_vld ? ram_rd.r : 8'd0);
            pal_c.g = r_byp_hit[1] ? r_byp_data.g : (pix_row_vld ? ram_rd.g : 8'd0);
            pal_c.b = r_byp_hit[2] ? r_byp_data.b : (pix_row_vld ? ram_rd.b : 8'd0);
        end
    end

    always_comb begin
        priority if (r_indexed_mode) begin
            pr = {pal_c.r, 2'b00};
            pg = {pal_c.g, 2'b00};
            pb = {pal_c.b, 2'b00};
        end else if (!r_rf[RF_AW'(REG_OUTPUT)][OUTPUT_RGB555_BIT]) begin
            pr = {2'b00, r_pix[15:11], 3'b000};
            pg = {2'b00, r_pix[10:5], 2'b00};
            pb = {2'b00, r_pix[4:0], 3'b000};
        end else begin
            pr = {2'b00, r_pix[14:10], 3'b000};
            pg = {2'b00, r_pix[9:5], 3'b000};
            pb = {2'b00, r_pix[4:0], 3'b000};
        end
    end

    // components overlap at the edges when shifted palette values reach bit 8
    assign argb = ALPHA_OPAQUE | (32'(pr) << 16) | (32'(pg) << 8) | 32'(pb);

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [31:0] n_read_data;
    logic [31:0] n_pixel_argb;
    logic [31:0] r_read_data;
    logic [31:0] r_pixel_argb;
    logic [9:0]  r_frame_width;
    logic [9:0]  r_frame_height;

    always_comb begin
        n_read_data  = 32'd0;
        n_pixel_argb = 32'd0;
        unique case (r_op)
            OP_WRITE: ;
            OP_READ:  n_read_data  = rf_hit ? rf_word : 32'd0;
            OP_PIXEL: n_pixel_argb = argb;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_data    <= n_read_data;
            r_pixel_argb   <= n_pixel_argb;
            r_frame_width  <= n_vis_w;
            r_frame_height <= n_vis_h;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_read_data;
    assign o_pixel_argb   = r_pixel_argb;
    assign o_frame_width  = r_frame_width;
    assign o_frame_height = r_frame_height;

endmodule

// ===== rtl/dpal_ram.sv =====
module dpal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a same-cycle write is not visible on the read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/display_regs_palette_pixel_expand_top_tb.sv =====
module display_regs_palette_pixel_expand_top_tb;
    import dpal_pkg::*;

    // Op code the block does not define: no state change, zero data
    localparam logic [1:0] OP_UNDEF = 2'd3;

    // Plain register words (no side effects)
    localparam logic [4:0] REG_FIRST   = 5'd0;
    localparam logic [4:0] REG_SCRATCH = 5'd5;
    localparam logic [4:0] REG_LAST    = 5'd31;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;    // quiet stretch after the last result

    // One bus/pixel item as it sits on the input ports
    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  reg_index;
        logic [31:0] write_data;
        logic [3:0]  byte_enable;
        logic [15:0] pixel_value;
    } t_bus_item;

    // One result as it sits on the output ports
    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] pixel_argb;
        logic [9:0]  frame_width;
        logic [9:0]  frame_height;
    } t_frame_result;

    // Directed stimulus row; typed rows carry their result written out by hand
    typedef struct packed {
        logic          mode;
        logic          typed;
        t_bus_item     item;
        t_frame_result want;
    } t_dir_row;

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic        i_cfg_wdata    = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op           = '0;
    logic [4:0]  i_reg_index    = '0;
    logic [31:0] i_write_data   = '0;
    logic [3:0]  i_byte_enable  = '0;
    logic [15:0] i_pixel_value  = '0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [31:0] o_read_data;
    logic [31:0] o_pixel_argb;
    logic [9:0]  o_frame_width;
    logic [9:0]  o_frame_height;

    display_regs_palette_pixel_expand_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_reg_index    (i_reg_index),
        .i_write_data   (i_write_data),
        .i_byte_enable  (i_byte_enable),
        .i_pixel_value  (i_pixel_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_read_data    (o_read_data),
        .o_pixel_argb   (o_pixel_argb),
        .o_frame_width  (o_frame_width),
        .o_frame_height (o_frame_height)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the block state
    // ------------------------------------------------------------------
    logic [31:0] reg_mirror [32];
    logic [7:0]  pal_mirror [768];     // R, G, B per entry
    logic [7:0]  pal_index;
    logic [1:0]  pal_comp;
    logic [9:0]  width_mirror;
    logic [9:0]  height_mirror;
    logic        mode_mirror;
    bit          mode_written = 1'b0;

    t_frame_result frames_pending [$];   // results still owed by the block
    t_dir_row      dir_rows [$];
    t_frame_result got_front;
    int            err_count   = 0;
    int            cycle_count = 0;
    int            burst_left  = 0;
    int            items_sent  = 0;
    logic [5:0]    rx_tick     = '0;
    logic [1:0]    rx_style    = '0;

    // Apply one accepted item to the shadow state, return what the block owes
    function automatic t_frame_result predict_frame(input t_bus_item it);
        t_frame_result res;
        logic [31:0]   lane_mask;
        logic [11:0]   span;
        logic [31:0]   r;
        logic [31:0]   g;
        logic [31:0]   b;
        int            slot;
        res.read_data  = '0;
        res.pixel_argb = '0;
        case (it.op)
            OP_WRITE: begin
                lane_mask = {{8{it.byte_enable[3]}}, {8{it.byte_enable[2]}},
                             {8{it.byte_enable[1]}}, {8{it.byte_enable[0]}}};
                reg_mirror[it.reg_index] = (reg_mirror[it.reg_index] & ~lane_mask)
                                         | (it.write_data & lane_mask);
                // side effects look at the full data word, enables or not
                case (it.reg_index)
                    REG_PAL_ADDR: begin
                        reg_mirror[REG_PAL_ADDR] = {24'd0, it.write_data[7:0]};
                        pal_index = it.write_data[7:0];
                        pal_comp  = COMP_R;
                    end
                    REG_PAL_DATA: begin
                        slot = int'(pal_index) * 3 + int'(pal_comp);
                        pal_mirror[slot] = it.write_data[7:0];
                        if (pal_comp == COMP_B) begin
                            pal_comp  = COMP_R;
                            pal_index = pal_index + 8'd1;   // wraps 255 -> 0
                        end else begin
                            pal_comp = pal_comp + 2'd1;
                        end
                        reg_mirror[REG_PAL_ADDR] = {24'd0, pal_index};
                    end
                    REG_HTIM1: begin
                        span = {1'b0, it.write_data[10:0]} + 12'd1;
                        if (reg_mirror[REG_TIMING][TIMING_HALVE_BIT]) begin
                            span = span >> 1;
                        end
                        span = span + WIDTH_PAD;
                        width_mirror = (span > WIDTH_MAX) ? WIDTH_MAX[9:0] : span[9:0];
                    end
                    REG_VTIM1: begin
                        span = {1'b0, it.write_data[10:0]} + 12'd1;
                        height_mirror = (span > HEIGHT_MAX) ? HEIGHT_MAX[9:0] : span[9:0];
                    end
                    default: ;
                endcase
            end
            OP_READ: begin
                res.read_data = reg_mirror[it.reg_index];
            end
            OP_PIXEL: begin
                if (mode_mirror) begin
                    // components shifted by 2 and ORed: neighbors may overlap
                    slot = int'(it.pixel_value[7:0]) * 3;
                    r = {24'd0, pal_mirror[slot]} << 2;
                    g = {24'd0, pal_mirror[slot + 1]} << 2;
                    b = {24'd0, pal_mirror[slot + 2]} << 2;
                end else if (!reg_mirror[REG_OUTPUT][OUTPUT_RGB555_BIT]) begin
                    r = {24'd0, it.pixel_value[15:11], 3'b0};
                    g = {24'd0, it.pixel_value[10:5], 2'b0};
                    b = {24'd0, it.pixel_value[4:0], 3'b0};
                end else begin
                    r = {24'd0, it.pixel_value[14:10], 3'b0};
                    g = {24'd0, it.pixel_value[9:5], 3'b0};
                    b = {24'd0, it.pixel_value[4:0], 3'b0};
                end
                res.pixel_argb = ALPHA_OPAQUE | (r << 16) | (g << 8) | b;
            end
            default: ;
        endcase
        res.frame_width  = width_mirror;
        res.frame_height = height_mirror;
        return res;
    endfunction

    function automatic t_bus_item mk_item(input logic [1:0] op, input logic [4:0] ri,
                                          input logic [31:0] wd, input logic [3:0] be,
                                          input logic [15:0] px);
        t_bus_item it;
        it.op          = op;
        it.reg_index   = ri;
        it.write_data  = wd;
        it.byte_enable = be;
        it.pixel_value = px;
        return it;
    endfunction

    // Half the time one of the registers with side effects
    function automatic logic [4:0] pick_reg();
        logic [4:0] hot [6];
        hot = '{REG_TIMING, REG_OUTPUT, REG_HTIM1, REG_VTIM1, REG_PAL_ADDR, REG_PAL_DATA};
        if ($urandom_range(0, 1) == 0) begin
            return hot[$urandom_range(0, 5)];
        end
        return 5'($urandom_range(0, 31));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, wanted %h", what, got, want);
        err_count++;
    endtask

    task automatic dir_row(input logic m, input logic [1:0] op, input logic [4:0] ri,
                           input logic [31:0] wd, input logic [3:0] be,
                           input logic [15:0] px, input logic typed,
                           input logic [31:0] rd, input logic [31:0] argb,
                           input logic [9:0] w, input logic [9:0] h);
        t_dir_row row;
        row.mode              = m;
        row.typed             = typed;
        row.item              = mk_item(op, ri, wd, be, px);
        row.want.read_data    = rd;
        row.want.pixel_argb   = argb;
        row.want.frame_width  = w;
        row.want.frame_height = h;
        dir_rows.push_back(row);
    endtask

    // Present one item; sender runs in bursts with random gaps in between.
    // Returns in the time step of the accepting edge, valid still high.
    task automatic drive_item(input t_bus_item it, input logic typed,
                              input t_frame_result want);
        int            gap;
        t_frame_result res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_op          <= it.op;
        i_reg_index   <= it.reg_index;
        i_write_data  <= it.write_data;
        i_byte_enable <= it.byte_enable;
        i_pixel_value <= it.pixel_value;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        res = predict_frame(it);
        if (typed) begin
            res = want;
        end
        frames_pending.push_back(res);
        items_sent++;
    endtask

    // Mode register only changes with the pipe empty
    task automatic set_mode(input logic m);
        if (!mode_written || m != mode_mirror) begin
            i_in_valid <= 1'b0;
            while (frames_pending.size() != 0) @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= m;
            @(posedge i_clk);
            i_cfg_we     <= 1'b0;
            mode_mirror  = m;
            mode_written = 1'b1;
        end
    endtask

    // Random traffic: palette programs, timing writes, reads, pixels, noise
    task automatic run_random_phase(input logic m, input int n_items);
        int         sent;
        int         pick;
        int         n_data;
        logic [7:0] pal_focus;
        logic [31:0] wd;
        logic [15:0] px;
        sent      = 0;
        pal_focus = 8'($urandom_range(0, 255));
        set_mode(m);
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                // palette program: address, then mostly whole RGB triples
                wd = $urandom;
                pal_focus = wd[7:0];
                drive_item(mk_item(OP_WRITE, REG_PAL_ADDR, wd, 4'($urandom_range(0, 15)),
                                   16'($urandom)), 1'b0, '0);
                n_data = 3 * $urandom_range(1, 3);
                if ($urandom_range(0, 4) == 0) begin
                    n_data = n_data + $urandom_range(1, 2);   // partial triple
                end
                repeat (n_data) begin
                    drive_item(mk_item(OP_WRITE, REG_PAL_DATA, $urandom,
                                       4'($urandom_range(0, 15)), 16'($urandom)), 1'b0, '0);
                end
                sent = sent + 1 + n_data;
            end else if (pick < 30) begin
                drive_item(mk_item(OP_WRITE, pick_reg(), $urandom, 4'($urandom_range(0, 15)),
                                   16'($urandom)), 1'b0, '0);
                sent++;
            end else if (pick < 47) begin
                drive_item(mk_item(OP_READ, pick_reg(), $urandom, 4'($urandom_range(0, 15)),
                                   16'($urandom)), 1'b0, '0);
                sent++;
            end else if (pick < 50) begin
                drive_item(mk_item(OP_UNDEF, 5'($urandom_range(0, 31)), $urandom,
                                   4'($urandom_range(0, 15)), 16'($urandom)), 1'b0, '0);
                sent++;
            end else begin
                px = 16'($urandom);
                // aim at recently programmed entries in indexed mode
                if (m && $urandom_range(0, 1) == 0) begin
                    px[7:0] = pal_focus + 8'($urandom_range(0, 2));
                end
                drive_item(mk_item(OP_PIXEL, 5'($urandom_range(0, 31)), $urandom,
                                   4'($urandom_range(0, 15)), px), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: stall style picked at random each time rx_tick wraps, including always-ready
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 6'd1;
        if (rx_tick == '0) begin
            rx_style <= 2'($urandom_range(0, 3));
        end
        case (rx_style)
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= ($urandom_range(0, 1) == 0);
            2'd2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= rx_tick[2];
        endcase
    end

    // ------------------------------------------------------------------
    // Result check against the oldest pending frame result
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (frames_pending.size() == 0) begin
                report_mismatch("result with nothing pending", o_read_data, '0);
            end else begin
                got_front = frames_pending.pop_front();
                if (o_read_data !== got_front.read_data) begin
                    report_mismatch("read_data", o_read_data, got_front.read_data);
                end
                if (o_pixel_argb !== got_front.pixel_argb) begin
                    report_mismatch("pixel_argb", o_pixel_argb, got_front.pixel_argb);
                end
                if (o_frame_width !== got_front.frame_width) begin
                    report_mismatch("frame_width", {22'd0, o_frame_width},
                                    {22'd0, got_front.frame_width});
                end
                if (o_frame_height !== got_front.frame_height) begin
                    report_mismatch("frame_height", {22'd0, o_frame_height},
                                    {22'd0, got_front.frame_height});
                end
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int   phase;
        logic first_mode;

        // shadow reset
        foreach (reg_mirror[k]) reg_mirror[k] = '0;
        foreach (pal_mirror[k]) pal_mirror[k] = '0;
        pal_index     = '0;
        pal_comp      = COMP_R;
        width_mirror  = WIDTH_RST;
        height_mirror = HEIGHT_RST;
        mode_mirror   = 1'b0;

        // Directed rows. Columns: mode, op, reg, data, enables, pixel,
        // typed, read_data, argb, width, height
        // reads and pixels straight after reset
        dir_row(0, OP_READ,  REG_FIRST,    32'h0,         4'hF, 16'h0000,
                1, 32'h0, 32'h0, 10'd640, 10'd480);
        dir_row(0, OP_PIXEL, REG_LAST,     32'h0,         4'h0, 16'h0000,
                1, 32'h0, 32'hFF00_0000, 10'd640, 10'd480);
        dir_row(0, OP_PIXEL, REG_FIRST,    32'h0,         4'h0, 16'hFFFF,
                1, 32'h0, 32'hFFF8_FCF8, 10'd640, 10'd480);
        // undefined op with every input bit high
        dir_row(0, OP_UNDEF, REG_LAST,     32'hFFFF_FFFF, 4'hF, 16'hFFFF,
                1, 32'h0, 32'h0, 10'd640, 10'd480);
        // switch to RGB555
        dir_row(0, OP_WRITE, REG_OUTPUT,   32'h0000_0002, 4'hF, 16'h0000,
                0, '0, '0, '0, '0);
        dir_row(0, OP_PIXEL, REG_FIRST,    32'h0,         4'h0, 16'hFFFF,
                1, 32'h0, 32'hFFF8_F8F8, 10'd640, 10'd480);
        // no lanes enabled: word kept
        dir_row(0, OP_WRITE, REG_OUTPUT,   32'hFFFF_FFFF, 4'h0, 16'h0000,
                0, '0, '0, '0, '0);
        dir_row(0, OP_READ,  REG_OUTPUT,   32'h0,         4'h0, 16'h0000,
                0, '0, '0, '0, '0);
        // height clamp, then side effect with no lanes enabled
        dir_row(0, OP_WRITE, REG_VTIM1,    32'hFFFF_FFFF, 4'hF, 16'h0000,
                1, 32'h0, 32'h0, 10'd640, 10'd600);
        dir_row(0, OP_WRITE, REG_VTIM1,    32'h0,         4'h0, 16'h0000,
                1, 32'h0, 32'h0, 10'd640, 10'd1);
        dir_row(0, OP_WRITE, REG_HTIM1,    32'h0,         4'hF, 16'h0000,
                1, 32'h0, 32'h0, 10'd5, 10'd1);
        // halve bit through a single byte lane, then width clamp
        dir_row(0, OP_WRITE, REG_TIMING,   32'h0000_8000, 4'h2, 16'h0000,
                0, '0, '0, '0, '0);
        dir_row(0, OP_WRITE, REG_HTIM1,    32'hFFFF_FFFF, 4'h0, 16'h0000,
                1, 32'h0, 32'h0, 10'd800, 10'd1);
        dir_row(0, OP_WRITE, REG_HTIM1,    32'h0000_0001, 4'hF, 16'h0000,
                0, '0, '0, '0, '0);
        // palette: start at 0xFE, two triples wrap the index to zero
        dir_row(0, OP_WRITE, REG_PAL_ADDR, 32'h0000_01FE, 4'h1, 16'h0000,
                0, '0, '0, '0, '0);
        dir_row(0, OP_WRITE, REG_PAL_DATA, 32'h0000_00FF, 4'hF, 16'h0000,
                0, '0, '0, '0, '0);
        dir_row(0, OP_WRITE, REG_PAL_DATA, 32'h0000_0080, 4'hF, 16'h0000,
                0, '0, '0, '0, '0);
        dir_row(0, OP_WRITE, REG_PAL_DATA, 32'h0000_0001, 4'hF, 16'h0000,
                0, '0, '0, '0, '0);
        dir_row(0, OP_WRITE, REG_PAL_DATA, 32'hFFFF_FFFF, 4'h0, 16'h0000,
                0, '0, '0, '0, '0);
        dir_row(0, OP_WRITE, REG_PAL_DATA, 32'h0000_0034, 4'hF, 16'h0000,
                0, '0, '0, '0, '0);
        dir_row(0, OP_WRITE, REG_PAL_DATA, 32'h0000_0056, 4'hF, 16'h0000,
                0, '0, '0, '0, '0);
        dir_row(0, OP_READ,  REG_PAL_ADDR, 32'h0,         4'h0, 16'h0000,
                0, '0, '0, '0, '0);
        // byte merge with alternate lanes
        dir_row(0, OP_WRITE, REG_SCRATCH,  32'hA5A5_A5A5, 4'h5, 16'h0000,
                0, '0, '0, '0, '0);
        dir_row(0, OP_READ,  REG_SCRATCH,  32'h0,         4'h0, 16'h0000,
                0, '0, '0, '0, '0);
        // indexed mode: overlapping components, then the wrapped entry
        dir_row(1, OP_PIXEL, REG_FIRST,    32'h0,         4'h0, 16'h00FF,
                0, '0, '0, '0, '0);
        dir_row(1, OP_PIXEL, REG_FIRST,    32'h0,         4'h0, 16'hFF00,
                0, '0, '0, '0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            set_mode(dir_rows[k].mode);
            drive_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
        end

        // random phases, mode alternating
        first_mode = 1'($urandom_range(0, 1));
        for (phase = 0; phase < 8; phase++) begin
            run_random_phase(first_mode ^ phase[0], $urandom_range(180, 260));
        end

        // drain, then a short quiet stretch for stray results
        i_in_valid <= 1'b0;
        while (frames_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
